>>> rtl/assert_macros.svh
// Assertion macros shared by the root solver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on each rising edge, held off while reset is high.
`define QRS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("root solver assertion failed");
// Check a property on each rising edge, reset included.
`define QRS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("root solver assertion failed");
`else
`define QRS_ASSERT(lbl, clk, rst, prop)
`define QRS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> rtl/qrs_pkg.sv
// Shared constants and types of the quadratic root solver.
`timescale 1ns / 1ps
package qrs_pkg;

   localparam int COEF_WIDTH_DEF     = 16;
   localparam int COEF_FRAC_BITS_DEF = 8;
   localparam int ROOT_WIDTH_DEF     = 32;

   typedef enum logic [1:0] {
      KIND_TWO    = 2'd0,
      KIND_DOUBLE = 2'd1,
      KIND_NONE   = 2'd2,
      KIND_DEGEN  = 2'd3
   } kind_type;

endpackage

>>> rtl/qrs_req_if.sv
// Request channel: the three coefficients with valid and ready.
`timescale 1ns / 1ps
interface qrs_req_if #(
   parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic signed [COEF_WIDTH-1:0] coef_a;
   logic signed [COEF_WIDTH-1:0] coef_b;
   logic signed [COEF_WIDTH-1:0] coef_c;

   modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
   modport sink (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

>>> rtl/qrs_rsp_if.sv
// Response channel: root kind, both roots and the saturation flag.
`timescale 1ns / 1ps
interface qrs_rsp_if #(
   parameter int ROOT_WIDTH = qrs_pkg::ROOT_WIDTH_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic [1:0]                   root_kind;
   logic signed [ROOT_WIDTH-1:0] root_plus;
   logic signed [ROOT_WIDTH-1:0] root_minus;
   logic                         saturated;

   modport source (output valid, output root_kind, output root_plus, output root_minus,
                   output saturated, input ready);
   modport sink (input valid, input root_kind, input root_plus, input root_minus,
                 input saturated, output ready);
endinterface

>>> rtl/quadratic_root_solver_unit.sv
// Pipelined real-root solver for a*x^2 + b*x + c = 0 in fixed point.
//
//   channel  dir  payload                                        moves
//   req      in   coef_a, coef_b, coef_c (signed, Q.F)           one request
//   rsp      out  root_kind, root_plus, root_minus, saturated    one result per request
//
// Stages in order: products, discriminant, the bit-per-stage square root (COEF_WIDTH+1
// stages), numerator, the bit-per-stage divider (COEF_WIDTH+COEF_FRAC_BITS+2 stages)
// and the output register. One request enters every cycle while rsp is not stalled.
// Reset is synchronous and clears only the valid bits of every stage.
// A stall on rsp freezes the whole pipe at once; req.ready drops in the same cycle,
// so nothing is lost or repeated.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module quadratic_root_solver_unit #(
   parameter int COEF_WIDTH     = qrs_pkg::COEF_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = qrs_pkg::COEF_FRAC_BITS_DEF,
   parameter int ROOT_WIDTH     = qrs_pkg::ROOT_WIDTH_DEF
) (
   input logic     clock,
   input logic     reset,
   qrs_req_if.sink   req,
   qrs_rsp_if.source rsp
);

   localparam int CW  = COEF_WIDTH;
   localparam int F   = COEF_FRAC_BITS;
   localparam int RW  = ROOT_WIDTH;
   localparam int PW  = 2 * CW;          // product width
   localparam int DW  = 2 * CW + 2;      // discriminant width
   localparam int Q   = CW + 1;          // square root width
   localparam int NW  = CW + 2 + F;      // dividend and quotient width
   localparam int DVW = CW + 1;          // divisor width
   localparam int EW  = ((NW + 1 > RW) ? NW + 1 : RW) + 1;  // saturation compare width

   // One enable for the whole pipe: advance unless the output register is held.
   logic adv;
   logic vout_ff;
   assign adv       = !vout_ff || rsp.ready;
   assign req.ready = adv;

   // ---------------------------------------------------------------------------------
   // Stage 1: products b*b and a*c, with coefficients a and b carried along.
   // ---------------------------------------------------------------------------------
   logic                 v1_ff;
   logic signed [PW-1:0] bb_ff;
   logic signed [PW-1:0] ac_ff;
   logic signed [CW-1:0] a1_ff;
   logic signed [CW-1:0] b1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bb_ff <= req.coef_b * req.coef_b;
         ac_ff <= req.coef_a * req.coef_c;
         a1_ff <= req.coef_a;
         b1_ff <= req.coef_b;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 2: discriminant and root kind. Its registers are entry 0 of the root pipe.
   // ---------------------------------------------------------------------------------
   logic signed [DW-1:0] delta_in;
   qrs_pkg::kind_type    kind2_in;

   assign delta_in = {{2{bb_ff[PW-1]}}, bb_ff} - {ac_ff, 2'b00};

   always_comb begin
      if (a1_ff == '0) begin
         kind2_in = qrs_pkg::KIND_DEGEN;
      end else if (delta_in[DW-1]) begin
         kind2_in = qrs_pkg::KIND_NONE;
      end else if (delta_in == '0) begin
         kind2_in = qrs_pkg::KIND_DOUBLE;
      end else begin
         kind2_in = qrs_pkg::KIND_TWO;
      end
   end

   // Square root pipe, one result bit per stage.
   logic                 sv_ff    [0:Q];
   logic [DW-1:0]        sx_ff    [0:Q];
   logic [Q:0]           srem_ff  [0:Q];
   logic [Q-1:0]         sroot_ff [0:Q];
   logic signed [CW-1:0] sa_ff    [0:Q];
   logic signed [CW-1:0] sb_ff    [0:Q];
   qrs_pkg::kind_type    sk_ff    [0:Q];

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[0] <= 1'b0;
      end else if (adv) begin
         sv_ff[0] <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sx_ff[0]    <= delta_in;
         srem_ff[0]  <= '0;
         sroot_ff[0] <= '0;
         sa_ff[0]    <= a1_ff;
         sb_ff[0]    <= b1_ff;
         sk_ff[0]    <= kind2_in;
      end
   end

   for (genvar k = 0; k < Q; k++) begin : g_sqrt
      logic [Q+2:0] rem_sh;
      logic [Q+2:0] trial;
      logic [Q+2:0] diff;
      logic         ge;

      assign rem_sh = {srem_ff[k], sx_ff[k][DW-1:DW-2]};
      assign trial  = {1'b0, sroot_ff[k], 2'b01};
      assign ge     = rem_sh >= trial;
      assign diff   = rem_sh - trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sv_ff[k+1] <= sv_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sx_ff[k+1]    <= {sx_ff[k][DW-3:0], 2'b00};
            srem_ff[k+1]  <= ge ? diff[Q:0] : rem_sh[Q:0];
            sroot_ff[k+1] <= {sroot_ff[k][Q-2:0], ge};
            sa_ff[k+1]    <= sa_ff[k];
            sb_ff[k+1]    <= sb_ff[k];
            sk_ff[k+1]    <= sk_ff[k];
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Numerator stage: -b +/- sqrt as sign and magnitude, divisor |2a|.
   // Its registers are entry 0 of the divider pipe.
   // ---------------------------------------------------------------------------------
   logic signed [CW+2:0] nb;
   logic signed [CW+2:0] ns;
   logic signed [CW+2:0] np;
   logic signed [CW+2:0] nm;
   logic [CW+2:0]        mag_p;
   logic [CW+2:0]        mag_m;
   logic signed [CW:0]   a_ext;
   logic [CW:0]          abs_a;

   assign nb    = -{{3{sb_ff[Q][CW-1]}}, sb_ff[Q]};
   assign ns    = {2'b00, sroot_ff[Q]};
   assign np    = nb + ns;
   assign nm    = nb - ns;
   assign mag_p = np[CW+2] ? -np : np;
   assign mag_m = nm[CW+2] ? -nm : nm;
   assign a_ext = {sa_ff[Q][CW-1], sa_ff[Q]};
   assign abs_a = a_ext[CW] ? -a_ext : a_ext;

   logic              dv_ff   [0:NW];
   logic [NW-1:0]     dqp_ff  [0:NW];
   logic [NW-1:0]     dqm_ff  [0:NW];
   logic [DVW-1:0]    drp_ff  [0:NW];
   logic [DVW-1:0]    drm_ff  [0:NW];
   logic [DVW-1:0]    dden_ff [0:NW];
   logic              dnp_ff  [0:NW];
   logic              dnm_ff  [0:NW];
   qrs_pkg::kind_type dk_ff   [0:NW];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= sv_ff[Q];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dqp_ff[0]  <= {mag_p[CW+1:0], {F{1'b0}}};
         dqm_ff[0]  <= {mag_m[CW+1:0], {F{1'b0}}};
         drp_ff[0]  <= '0;
         drm_ff[0]  <= '0;
         dden_ff[0] <= {abs_a[CW-1:0], 1'b0};
         dnp_ff[0]  <= np[CW+2] ^ sa_ff[Q][CW-1];
         dnm_ff[0]  <= nm[CW+2] ^ sa_ff[Q][CW-1];
         dk_ff[0]   <= sk_ff[Q];
      end
   end

   // Two restoring dividers side by side, one quotient bit per stage.
   for (genvar k = 0; k < NW; k++) begin : g_div
      logic [DVW:0] shp;
      logic [DVW:0] shm;
      logic [DVW:0] dif_p;
      logic [DVW:0] dif_m;
      logic         gep;
      logic         gem;

      assign shp   = {drp_ff[k], dqp_ff[k][NW-1]};
      assign shm   = {drm_ff[k], dqm_ff[k][NW-1]};
      assign dif_p = shp - {1'b0, dden_ff[k]};
      assign dif_m = shm - {1'b0, dden_ff[k]};
      assign gep   = shp >= {1'b0, dden_ff[k]};
      assign gem   = shm >= {1'b0, dden_ff[k]};

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dv_ff[k+1] <= dv_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dqp_ff[k+1]  <= {dqp_ff[k][NW-2:0], gep};
            dqm_ff[k+1]  <= {dqm_ff[k][NW-2:0], gem};
            drp_ff[k+1]  <= gep ? dif_p[DVW-1:0] : shp[DVW-1:0];
            drm_ff[k+1]  <= gem ? dif_m[DVW-1:0] : shm[DVW-1:0];
            dden_ff[k+1] <= dden_ff[k];
            dnp_ff[k+1]  <= dnp_ff[k];
            dnm_ff[k+1]  <= dnm_ff[k];
            dk_ff[k+1]   <= dk_ff[k];
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Output stage: apply sign, clip to the root range, zero roots with no real value.
   // ---------------------------------------------------------------------------------
   logic signed [NW:0]   qp_s;
   logic signed [NW:0]   qm_s;
   logic signed [EW-1:0] qp_e;
   logic signed [EW-1:0] qm_e;
   logic signed [EW-1:0] rmax_e;
   logic signed [EW-1:0] rmin_e;
   logic                 satp;
   logic                 satm;
   logic [RW-1:0]        rootp;
   logic [RW-1:0]        rootm;
   logic                 real_roots;

   assign qp_s   = dnp_ff[NW] ? -{1'b0, dqp_ff[NW]} : {1'b0, dqp_ff[NW]};
   assign qm_s   = dnm_ff[NW] ? -{1'b0, dqm_ff[NW]} : {1'b0, dqm_ff[NW]};
   assign qp_e   = {{(EW-NW-1){qp_s[NW]}}, qp_s};
   assign qm_e   = {{(EW-NW-1){qm_s[NW]}}, qm_s};
   assign rmax_e = {{(EW-RW+1){1'b0}}, {(RW-1){1'b1}}};
   assign rmin_e = ~rmax_e;
   assign satp   = (qp_e > rmax_e) || (qp_e < rmin_e);
   assign satm   = (qm_e > rmax_e) || (qm_e < rmin_e);
   assign rootp  = satp ? (qp_e[EW-1] ? rmin_e[RW-1:0] : rmax_e[RW-1:0]) : qp_e[RW-1:0];
   assign rootm  = satm ? (qm_e[EW-1] ? rmin_e[RW-1:0] : rmax_e[RW-1:0]) : qm_e[RW-1:0];
   assign real_roots = (dk_ff[NW] == qrs_pkg::KIND_TWO) || (dk_ff[NW] == qrs_pkg::KIND_DOUBLE);

   qrs_pkg::kind_type kind_out_ff;
   logic [RW-1:0]     rp_out_ff;
   logic [RW-1:0]     rm_out_ff;
   logic              sat_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vout_ff <= 1'b0;
      end else if (adv) begin
         vout_ff <= dv_ff[NW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kind_out_ff <= dk_ff[NW];
         rp_out_ff   <= real_roots ? rootp : '0;
         rm_out_ff   <= real_roots ? rootm : '0;
         sat_out_ff  <= real_roots && (satp || satm);
      end
   end

   assign rsp.valid      = vout_ff;
   assign rsp.root_kind  = kind_out_ff;
   assign rsp.root_plus  = rp_out_ff;
   assign rsp.root_minus = rm_out_ff;
   assign rsp.saturated  = sat_out_ff;

   logic real_roots_out;
   logic double_out;
   logic roots_clear;
   assign real_roots_out = (kind_out_ff == qrs_pkg::KIND_TWO) ||
                           (kind_out_ff == qrs_pkg::KIND_DOUBLE);
   assign double_out     = kind_out_ff == qrs_pkg::KIND_DOUBLE;
   assign roots_clear    = (rp_out_ff == '0) && (rm_out_ff == '0) && !sat_out_ff;

   // Degenerate and rootless results carry zero roots and no clip flag.
   `QRS_ASSERT(a_no_roots_zero, clock, reset, vout_ff && !real_roots_out |-> roots_clear)
   // A double root shows the same value in both root fields.
   `QRS_ASSERT(a_double_equal, clock, reset, vout_ff && double_out |-> rp_out_ff == rm_out_ff)
   // Ready follows the output register: a held result blocks new requests.
   `QRS_ASSERT(a_hold_blocks, clock, reset, vout_ff && !rsp.ready |-> !req.ready)
   // Synchronous reset empties the output register on the next edge.
   `QRS_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !vout_ff)

endmodule
